// ----- rtl/fcsu_pkg.sv -----
package fcsu_pkg;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_READ  = 2'd2,
		REQ_NONE  = 2'd3
	} req_type_e;

	localparam logic [15:0] ADDR_SWEEP   = 16'hFF10;
	localparam logic [15:0] ADDR_SQ0_LO  = 16'hFF11;
	localparam logic [15:0] ADDR_SQ0_ENV = 16'hFF12;
	localparam logic [15:0] ADDR_SQ0_HI  = 16'hFF14;
	localparam logic [15:0] ADDR_SQ1_LO  = 16'hFF16;
	localparam logic [15:0] ADDR_SQ1_ENV = 16'hFF17;
	localparam logic [15:0] ADDR_SQ1_HI  = 16'hFF19;
	localparam logic [15:0] ADDR_WCTRL   = 16'hFF1A;
	localparam logic [15:0] ADDR_WLEN    = 16'hFF1B;
	localparam logic [15:0] ADDR_WLEVEL  = 16'hFF1C;
	localparam logic [15:0] ADDR_WFLO    = 16'hFF1D;
	localparam logic [15:0] ADDR_WFHI    = 16'hFF1E;
	localparam logic [15:0] ADDR_NLEN    = 16'hFF20;
	localparam logic [15:0] ADDR_NENV    = 16'hFF21;
	localparam logic [15:0] ADDR_NPOLY   = 16'hFF22;
	localparam logic [15:0] ADDR_NCTRL   = 16'hFF23;
	localparam logic [15:0] ADDR_MVOL    = 16'hFF24;
	localparam logic [15:0] ADDR_PAN     = 16'hFF25;
	localparam logic [15:0] ADDR_MCTRL   = 16'hFF26;
	localparam logic [11:0] ADDR_WMEM    = 12'hFF3;

	localparam logic [15:0] SQ0_BASE = 16'hFF10;
	localparam logic [15:0] SQ1_BASE = 16'hFF15;

	localparam logic [2:0] SQ_REG_LEN = 3'd1;
	localparam logic [2:0] SQ_REG_ENV = 3'd2;
	localparam logic [2:0] SQ_REG_FLO = 3'd3;
	localparam logic [2:0] SQ_REG_FHI = 3'd4;

	localparam logic [13:0] FRAME_LEN = 14'd8192;

	typedef struct packed {
		logic [7:0]  duty;
		logic [7:0]  env;
		logic [7:0]  flo;
		logic [7:0]  fhi;
		logic        active;
		logic        dac;
		logic [6:0]  len;
		logic [3:0]  elvl;
		logic        rise;
		logic [2:0]  eper;
		logic [2:0]  etmr;
		logic [3:0]  level;
		logic [2:0]  step;
		logic [20:0] cd;
	} sq_t;

	typedef struct packed {
		logic        unit_on;
		logic [13:0] frame_cnt;
		logic [7:0]  mvol;
		logic [7:0]  pan;
		logic [7:0]  mctrl;
		logic [7:0]  sweep;
		sq_t [1:0]   sq;
		logic [7:0]  wctrl;
		logic [7:0]  wlevel;
		logic [7:0]  wflo;
		logic [7:0]  wfhi;
		logic        wactive;
		logic        wdac;
		logic [8:0]  wlen;
		logic [4:0]  wstep;
		logic [20:0] wcd;
		logic [7:0]  nenv;
		logic [7:0]  npoly;
		logic [7:0]  nctrl;
		logic        nactive;
		logic        ndac;
		logic [6:0]  nlen;
		logic [3:0]  nelvl;
		logic        nrise;
		logic [2:0]  neper;
		logic [2:0]  netmr;
		logic [3:0]  nlevel;
		logic [14:0] nsr;
		logic        nbit;
		logic [19:0] nperiod;
		logic [20:0] ncd;
	} state_t;

	typedef struct packed {
		logic [2:0] tmr;
		logic [3:0] elvl;
		logic [3:0] level;
	} env_t;

	typedef struct packed {
		logic        stepped;
		logic [20:0] cd;
	} cd_t;

	function automatic logic [13:0] tone_period(input logic [7:0] lo, input logic [7:0] hi);
		logic [11:0] p;
		p = 12'd2048 - {1'b0, hi[2:0], lo};
		return {p, 2'b00};
	endfunction

	function automatic cd_t cd_run(input logic [20:0] cd, input logic [7:0] cyc,
		input logic [19:0] per);
		logic signed [21:0] v;
		cd_t r;
		v = $signed({cd[20], cd}) - $signed({14'd0, cyc});
		if (v < -22'sd1048576) v = -22'sd1048576;
		r.stepped = 1'b0;
		if (v <= 22'sd0) begin
			v = v + $signed({2'b00, per});
			r.stepped = 1'b1;
		end
		r.cd = v[20:0];
		return r;
	endfunction

	function automatic env_t env_clock(input logic [2:0] per, input logic rise, input env_t e);
		env_t r;
		r = e;
		if (per != 3'd0) begin
			r.tmr = e.tmr - 3'd1;
			if (r.tmr == 3'd0) begin
				r.tmr = per;
				if (rise && e.elvl != 4'd15) r.elvl = e.elvl + 4'd1;
				else if (!rise && e.elvl != 4'd0) r.elvl = e.elvl - 4'd1;
				r.level = r.elvl;
			end
		end
		return r;
	endfunction

	function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] step);
		logic [7:0] pat;
		case (duty)
			2'd0:    pat = 8'b1000_0000;
			2'd1:    pat = 8'b1000_0001;
			2'd2:    pat = 8'b1110_0001;
			default: pat = 8'b0111_1110;
		endcase
		return pat[step];
	endfunction

	// volume * 2048/7, rounded up; exact floor division for sums up to 60
	function automatic logic [11:0] vol_recip(input logic [2:0] vol);
		logic [11:0] k;
		case (vol)
			3'd0:    k = 12'd0;
			3'd1:    k = 12'd293;
			3'd2:    k = 12'd586;
			3'd3:    k = 12'd878;
			3'd4:    k = 12'd1171;
			3'd5:    k = 12'd1463;
			3'd6:    k = 12'd1756;
			default: k = 12'd2048;
		endcase
		return k;
	endfunction

endpackage

// ----- rtl/fcsu_if.sv -----
interface fcsu_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic [7:0]  tick_cycles;
	modport source (output valid, req_type, address, write_data, tick_cycles, input ready);
	modport sink (input valid, req_type, address, write_data, tick_cycles, output ready);
endinterface

interface fcsu_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [5:0] left_level;
	logic [5:0] right_level;
	modport source (output valid, read_data, left_level, right_level, input ready);
	modport sink (input valid, read_data, left_level, right_level, output ready);
endinterface

// ----- rtl/fcsu_core.sv -----
module fcsu_core
	import fcsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        acc,
	input  logic [1:0]  req_type,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic [7:0]  tick_cycles,
	output state_t      state,
	output logic [3:0]  wave_nibble,
	output logic [7:0]  reg_rd,
	output logic        mem_sel,
	output logic [7:0]  mem_rd_s1
);

	localparam state_t STATE_RST = '{unit_on: 1'b1, mvol: 8'h77, pan: 8'hF3,
		mctrl: 8'hF1, default: '0};

	state_t      state_q, state_d;
	logic [7:0]  wmem [16];
	logic [15:0] wmem_vld_q;
	logic [7:0]  wbyte_q;
	logic        wsel_q;
	logic        mem_wr, wstep_evt;
	logic        is_tick, is_wr, is_rd;

	assign state = state_q;
	assign wave_nibble = wsel_q ? wbyte_q[3:0] : wbyte_q[7:4];

	always_comb begin
		state_t st;
		env_t   e;
		cd_t    c;
		logic [14:0] fsum;
		logic [15:0] a;
		logic [3:0]  nd;
		logic        fclk;
		st = state_q;
		a = address;
		is_tick = acc && req_type_e'(req_type) == REQ_TICK && state_q.unit_on;
		is_wr = acc && req_type_e'(req_type) == REQ_WRITE &&
			(state_q.unit_on || a == ADDR_MCTRL);
		is_rd = req_type_e'(req_type) == REQ_READ;
		mem_wr = 1'b0;
		wstep_evt = 1'b0;
		fsum = {1'b0, state_q.frame_cnt} + {7'd0, tick_cycles};
		fclk = fsum >= {1'b0, FRAME_LEN};
		nd = 4'd0;
		e = '0;
		c = '0;

		if (is_tick) begin
			st.frame_cnt = fclk ? 14'(fsum - {1'b0, FRAME_LEN}) : fsum[13:0];
			if (fclk && st.frame_cnt[0]) begin
				for (int i = 0; i < 2; i++) begin
					if (st.sq[i].len != 7'd0) begin
						st.sq[i].len = st.sq[i].len - 7'd1;
						if (st.sq[i].len == 7'd0) st.sq[i].active = 1'b0;
					end
				end
				if (st.wlen != 9'd0) begin
					st.wlen = st.wlen - 9'd1;
					if (st.wlen == 9'd0) st.wactive = 1'b0;
				end
				if (st.nlen != 7'd0) begin
					st.nlen = st.nlen - 7'd1;
					if (st.nlen == 7'd0) st.nactive = 1'b0;
				end
			end
			if (fclk && st.frame_cnt[1:0] == 2'd2) begin
				for (int i = 0; i < 2; i++) begin
					e = env_clock(st.sq[i].eper, st.sq[i].rise,
						'{st.sq[i].etmr, st.sq[i].elvl, st.sq[i].level});
					st.sq[i].etmr = e.tmr;
					st.sq[i].elvl = e.elvl;
					st.sq[i].level = e.level;
				end
				e = env_clock(st.neper, st.nrise, '{st.netmr, st.nelvl, st.nlevel});
				st.netmr = e.tmr;
				st.nelvl = e.elvl;
				st.nlevel = e.level;
			end
			for (int i = 0; i < 2; i++) begin
				if (st.sq[i].active && st.sq[i].dac) begin
					c = cd_run(st.sq[i].cd, tick_cycles,
						{6'd0, tone_period(st.sq[i].flo, st.sq[i].fhi)});
					st.sq[i].cd = c.cd;
					if (c.stepped) st.sq[i].step = st.sq[i].step + 3'd1;
				end
			end
			if (st.wactive && st.wdac) begin
				c = cd_run(st.wcd, tick_cycles, {6'd0, tone_period(st.wflo, st.wfhi)});
				st.wcd = c.cd;
				if (c.stepped) begin
					st.wstep = st.wstep + 5'd1;
					wstep_evt = 1'b1;
				end
			end
			if (st.nactive && st.ndac) begin
				c = cd_run(st.ncd, tick_cycles, st.nperiod);
				st.ncd = c.cd;
				if (c.stepped) begin
					st.nsr = {st.nsr[0] ^ st.nsr[1], st.nsr[14:1]};
					st.nbit = st.nsr[0];
				end
			end
		end

		if (is_wr) begin
			for (int i = 0; i < 2; i++) begin
				logic [15:0] base;
				logic [2:0]  r;
				base = (i == 0) ? SQ0_BASE : SQ1_BASE;
				r = 3'(a - base);
				if ((i == 0 && a inside {[ADDR_SQ0_LO:ADDR_SQ0_HI]}) ||
					(i == 1 && a inside {[ADDR_SQ1_LO:ADDR_SQ1_HI]})) begin
					case (r)
						SQ_REG_LEN: begin
							st.sq[i].duty = write_data;
							st.sq[i].len = 7'd64 - {1'b0, write_data[5:0]};
						end
						SQ_REG_ENV: begin
							st.sq[i].env = write_data;
							st.sq[i].elvl = write_data[7:4];
							st.sq[i].rise = write_data[3];
							st.sq[i].eper = write_data[2:0];
							st.sq[i].etmr = write_data[2:0];
							st.sq[i].dac = write_data[7:3] != 5'd0;
						end
						SQ_REG_FLO: st.sq[i].flo = write_data;
						SQ_REG_FHI: begin
							st.sq[i].fhi = write_data;
							if (write_data[7]) begin
								st.sq[i].active = 1'b1;
								st.sq[i].cd = {7'd0, tone_period(st.sq[i].flo, write_data)};
								st.sq[i].step = 3'd0;
								st.sq[i].level = st.sq[i].elvl;
							end
						end
						default: ;
					endcase
				end
			end
			if (a[15:4] == ADDR_WMEM) mem_wr = 1'b1;
			case (a)
				ADDR_SWEEP: st.sweep = write_data;
				ADDR_WCTRL: begin
					st.wctrl = write_data;
					st.wdac = write_data[7];
				end
				ADDR_WLEN:   st.wlen = 9'd256 - {1'b0, write_data};
				ADDR_WLEVEL: st.wlevel = write_data;
				ADDR_WFLO:   st.wflo = write_data;
				ADDR_WFHI: begin
					st.wfhi = write_data;
					if (write_data[7]) begin
						st.wactive = 1'b1;
						st.wcd = {7'd0, tone_period(st.wflo, write_data)};
						st.wstep = 5'd0;
					end
				end
				ADDR_NLEN: st.nlen = 7'd64 - {1'b0, write_data[5:0]};
				ADDR_NENV: begin
					st.nenv = write_data;
					st.nelvl = write_data[7:4];
					st.nrise = write_data[3];
					st.neper = write_data[2:0];
					st.netmr = write_data[2:0];
					st.ndac = write_data[7:3] != 5'd0;
				end
				ADDR_NPOLY: begin
					nd = (write_data[2:0] == 3'd0) ? 4'd8 : {1'b0, write_data[2:0]};
					st.npoly = write_data;
					st.nperiod = {15'd0, nd, 1'b0} << write_data[7:4];
				end
				ADDR_NCTRL: begin
					st.nctrl = write_data;
					if (write_data[7]) begin
						st.nactive = 1'b1;
						st.ncd = {1'b0, st.nperiod};
						st.nsr = 15'h7FFF;
						st.nlevel = st.nelvl;
					end
				end
				ADDR_MVOL: st.mvol = write_data;
				ADDR_PAN:  st.pan = write_data;
				ADDR_MCTRL: begin
					st.mctrl = write_data;
					st.unit_on = write_data[7];
					if (!write_data[7]) begin
						st.sq[0].active = 1'b0;
						st.sq[1].active = 1'b0;
						st.wactive = 1'b0;
						st.nactive = 1'b0;
					end
				end
				default: ;
			endcase
		end
		state_d = st;
	end

	// read path, register part; wave memory bytes come through mem_rd_s1
	always_comb begin
		mem_sel = is_rd && state_q.unit_on && address[15:4] == ADDR_WMEM;
		reg_rd = 8'hFF;
		if (!is_rd) begin
			reg_rd = 8'h00;
		end else if (state_q.unit_on || address == ADDR_MCTRL) begin
			case (address)
				ADDR_SWEEP:   reg_rd = state_q.sweep | 8'h80;
				ADDR_SQ0_LO:  reg_rd = state_q.sq[0].duty | 8'h3F;
				ADDR_SQ0_ENV: reg_rd = state_q.sq[0].env;
				ADDR_SQ0_HI:  reg_rd = state_q.sq[0].fhi | 8'hBF;
				ADDR_SQ1_LO:  reg_rd = state_q.sq[1].duty | 8'h3F;
				ADDR_SQ1_ENV: reg_rd = state_q.sq[1].env;
				ADDR_SQ1_HI:  reg_rd = state_q.sq[1].fhi | 8'hBF;
				ADDR_WCTRL:   reg_rd = state_q.wctrl | 8'h7F;
				ADDR_WLEVEL:  reg_rd = state_q.wlevel | 8'h9F;
				ADDR_WFHI:    reg_rd = state_q.wfhi | 8'hBF;
				ADDR_NENV:    reg_rd = state_q.nenv;
				ADDR_NPOLY:   reg_rd = state_q.npoly;
				ADDR_NCTRL:   reg_rd = state_q.nctrl | 8'hBF;
				ADDR_MVOL:    reg_rd = state_q.mvol;
				ADDR_PAN:     reg_rd = state_q.pan;
				ADDR_MCTRL:   reg_rd = state_q.mctrl | 8'h70;
				default:      reg_rd = 8'hFF;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RST;
			wmem_vld_q <= '0;
			wbyte_q <= '0;
			wsel_q <= 1'b0;
		end else begin
			if (acc) state_q <= state_d;
			if (mem_wr) wmem_vld_q[address[3:0]] <= 1'b1;
			if (wstep_evt) begin
				wbyte_q <= wmem_vld_q[state_d.wstep[4:1]] ? wmem[state_d.wstep[4:1]] : 8'h00;
				wsel_q <= state_d.wstep[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr) wmem[address[3:0]] <= write_data;
		if (acc) mem_rd_s1 <= wmem_vld_q[address[3:0]] ? wmem[address[3:0]] : 8'h00;
	end

endmodule

// ----- rtl/fcsu_mix.sv -----
module fcsu_mix
	import fcsu_pkg::*;
(
	input  state_t     state,
	input  logic [3:0] wave_nibble,
	output logic [5:0] left_level,
	output logic [5:0] right_level
);

	logic [3:0]  s_sq [2];
	logic [3:0]  s_wave, s_noise;
	logic [5:0]  lsum, rsum;
	logic [17:0] lprod, rprod;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			s_sq[i] = (state.sq[i].active && state.sq[i].dac &&
				duty_bit(state.sq[i].duty[7:6], state.sq[i].step)) ? state.sq[i].level : 4'd0;
		end
		s_wave = 4'd0;
		if (state.wactive && state.wdac) begin
			case (state.wlevel[6:5])
				2'd1:    s_wave = wave_nibble >> 3;
				2'd2:    s_wave = wave_nibble >> 2;
				2'd3:    s_wave = wave_nibble >> 1;
				default: s_wave = 4'd0;
			endcase
		end
		s_noise = (state.nactive && state.ndac && state.nbit) ? state.nlevel : 4'd0;

		lsum = ((state.pan & 8'h11) != 8'h00 ? {2'd0, s_sq[0]} : 6'd0)
			+ ((state.pan & 8'h12) != 8'h00 ? {2'd0, s_sq[1]} : 6'd0)
			+ ((state.pan & 8'h14) != 8'h00 ? {2'd0, s_wave} : 6'd0)
			+ ((state.pan & 8'h18) != 8'h00 ? {2'd0, s_noise} : 6'd0);
		rsum = ((state.pan & 8'h22) != 8'h00 ? {2'd0, s_sq[0]} : 6'd0)
			+ ((state.pan & 8'h24) != 8'h00 ? {2'd0, s_sq[1]} : 6'd0)
			+ ((state.pan & 8'h28) != 8'h00 ? {2'd0, s_wave} : 6'd0)
			+ ((state.pan & 8'h30) != 8'h00 ? {2'd0, s_noise} : 6'd0);

		// sum * vol / 7 as one multiply by a scaled reciprocal
		lprod = {12'd0, lsum} * {6'd0, vol_recip(state.mvol[6:4])};
		rprod = {12'd0, rsum} * {6'd0, vol_recip(state.mvol[2:0])};
		left_level = lprod[16:11];
		right_level = rprod[16:11];
	end

endmodule

// ----- rtl/four_channel_sound_unit.sv -----
// flow: an accepted request is registered in stage 1 (rd_s1, mem_sel_s1), then
// moves into the result register when that register is free or being taken
// throughput: one request per cycle; a stalled result holds the staging register
// and then the request side, without losing items
// reset: arst_n clears all control state at once; registers take their power-on
// values and the wave memory reads as zero until written
module four_channel_sound_unit
	import fcsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	fcsu_req_if.sink   req,
	fcsu_rsp_if.source rsp
);

	logic       acc, s1_adv;
	logic       valid_s1, mem_sel_s1;
	logic [7:0] rd_s1, reg_rd, mem_rd_s1;
	logic       mem_sel;
	logic       out_valid_q;
	logic [7:0] out_rd_q;
	logic [5:0] out_l_q, out_r_q, mix_l, mix_r;
	logic [3:0] wave_nibble;
	state_t     state;

	assign s1_adv = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || s1_adv;
	assign acc = req.valid && req.ready;

	fcsu_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.req_type    (req.req_type),
		.address     (req.address),
		.write_data  (req.write_data),
		.tick_cycles (req.tick_cycles),
		.state       (state),
		.wave_nibble (wave_nibble),
		.reg_rd      (reg_rd),
		.mem_sel     (mem_sel),
		.mem_rd_s1   (mem_rd_s1)
	);

	// state already reflects the stage-1 item while it waits here
	fcsu_mix u_mix (
		.state       (state),
		.wave_nibble (wave_nibble),
		.left_level  (mix_l),
		.right_level (mix_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) valid_s1 <= 1'b1;
			else if (s1_adv) valid_s1 <= 1'b0;
			if (s1_adv) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1 <= reg_rd;
			mem_sel_s1 <= mem_sel;
		end
		if (s1_adv) begin
			out_rd_q <= mem_sel_s1 ? mem_rd_s1 : rd_s1;
			out_l_q <= mix_l;
			out_r_q <= mix_r;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.read_data = out_rd_q;
	assign rsp.left_level = out_l_q;
	assign rsp.right_level = out_r_q;

endmodule

// ----- rtl/fcsu_checker.sv -----
module fcsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] read_data,
	input logic [5:0] left_level,
	input logic [5:0] right_level
);

	logic [1:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc = req_valid && req_ready;
	assign out_acc = rsp_valid && rsp_ready;

	// transactions taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= '0;
		else pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) &&
		$stable(left_level) && $stable(right_level))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("result without a pending transaction");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd2 && !rsp_ready |-> !req_ready)
		else $error("request taken with both stages full");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> left_level <= 6'd60 && right_level <= 6'd60)
		else $error("mix level out of range");

endmodule

bind four_channel_sound_unit fcsu_checker u_fcsu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.read_data   (rsp.read_data),
	.left_level  (rsp.left_level),
	.right_level (rsp.right_level)
);
